@@ hdl/ps2_mouse_packet_cursor_macros.svh @@
// assertion macros for the ps2 mouse packet cursor checker
`ifndef PS2_MOUSE_PACKET_CURSOR_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_MACROS_SVH

// same-cycle implication, reset masks the check
`define PMPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define PMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pmpc_pkg.sv @@
// shared types and constants of the ps2 mouse packet cursor
package pmpc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int SIZE_W         = 12;
  localparam int CURSOR_W       = 12;
  localparam int DELTA_W        = 9;
  localparam int BYTE_W         = 8;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_PAD_W      = 1;
  localparam int OUT_TDATA_W    = 48;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd768;

  // register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // byte position inside a packet
  localparam logic [1:0] PH_STATUS = 2'd0;
  localparam logic [1:0] PH_X      = 2'd1;
  localparam logic [1:0] PH_Y      = 2'd2;

  // status byte bits
  localparam int ST_LEFT   = 0;
  localparam int ST_RIGHT  = 1;
  localparam int ST_MIDDLE = 2;
  localparam int ST_X_SIGN = 4;
  localparam int ST_Y_SIGN = 5;
  localparam int ST_X_OVF  = 6;
  localparam int ST_Y_OVF  = 7;

  typedef struct packed {
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] x_byte;
    logic [BYTE_W-1:0] y_byte;
  } pkt_t;

  typedef struct packed {
    logic               ovf_y;
    logic               ovf_x;
    logic               btn_middle;
    logic               btn_right;
    logic               btn_left;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [DELTA_W-1:0] delta_x;
    logic [CURSOR_W-1:0] cursor_y;
    logic [CURSOR_W-1:0] cursor_x;
  } res_t;

endpackage

@@ hdl/pmpc_framer.sv @@
// byte counter that collects the three bytes of a mouse packet
module pmpc_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [pmpc_pkg::BYTE_W-1:0]   byte_i,
  output logic                          done_o,
  output pmpc_pkg::pkt_t                pkt_o
);

  logic [1:0]                        phase_q, phase_d;
  logic [pmpc_pkg::BYTE_W-1:0]       status_q;
  logic [pmpc_pkg::BYTE_W-1:0]       xbyte_q;

  always_comb begin
    case (phase_q)
      pmpc_pkg::PH_X:  phase_d = pmpc_pkg::PH_Y;
      pmpc_pkg::PH_Y:  phase_d = pmpc_pkg::PH_STATUS;
      default:         phase_d = pmpc_pkg::PH_X;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pmpc_pkg::PH_STATUS;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      case (phase_q)
        pmpc_pkg::PH_X: begin
          xbyte_q <= byte_i;
        end
        pmpc_pkg::PH_Y: begin
          xbyte_q <= xbyte_q;
        end
        default: begin
          status_q <= byte_i;
        end
      endcase
    end
  end

  assign done_o       = step_i && (phase_q == pmpc_pkg::PH_Y);
  assign pkt_o.status = status_q;
  assign pkt_o.x_byte = xbyte_q;
  assign pkt_o.y_byte = byte_i;

endmodule

@@ hdl/pmpc_cursor.sv @@
// cursor position register with delta add and screen clamp
module pmpc_cursor #(
  parameter int COORD_BITS = pmpc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  pmpc_pkg::pkt_t                pkt_i,
  input  logic [pmpc_pkg::SIZE_W-1:0]   width_i,
  input  logic [pmpc_pkg::SIZE_W-1:0]   height_i,
  output pmpc_pkg::res_t                res_o
);

  localparam int VW = COORD_BITS + 2;
  localparam int TW = (COORD_BITS > pmpc_pkg::SIZE_W) ? COORD_BITS : pmpc_pkg::SIZE_W;
  localparam logic [TW-1:0] CMax = TW'((64'd1 << COORD_BITS) - 64'd1);

  logic [COORD_BITS-1:0]              pos_x_q, pos_y_q;
  logic [COORD_BITS-1:0]              pos_x_d, pos_y_d;
  logic signed [pmpc_pkg::DELTA_W-1:0] dx, dy;
  logic signed [VW-1:0]               vx, vy;

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [VW-1:0] v,
                                                  input logic [pmpc_pkg::SIZE_W-1:0] size);
    logic [pmpc_pkg::SIZE_W-1:0] sm1;
    logic [TW-1:0]               top_w;
    sm1   = (size == '0) ? '0 : size - 1'b1;
    top_w = TW'(sm1);
    if (top_w > CMax) begin
      top_w = CMax;
    end
    if (v[VW-1] || (v == '0)) begin
      return '0;
    end else if (v > $signed({2'b00, top_w[COORD_BITS-1:0]})) begin
      return top_w[COORD_BITS-1:0];
    end else begin
      return v[COORD_BITS-1:0];
    end
  endfunction

  assign dx = {pkt_i.status[pmpc_pkg::ST_X_SIGN], pkt_i.x_byte};
  assign dy = {pkt_i.status[pmpc_pkg::ST_Y_SIGN], pkt_i.y_byte};

  // rows grow downward, so y moves against the mouse
  assign vx = $signed({2'b00, pos_x_q}) + VW'(dx);
  assign vy = $signed({2'b00, pos_y_q}) - VW'(dy);

  assign pos_x_d = clamp(vx, width_i);
  assign pos_y_d = clamp(vy, height_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (step_i) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

  assign res_o.cursor_x   = pmpc_pkg::CURSOR_W'(pos_x_d);
  assign res_o.cursor_y   = pmpc_pkg::CURSOR_W'(pos_y_d);
  assign res_o.delta_x    = dx;
  assign res_o.delta_y    = dy;
  assign res_o.btn_left   = pkt_i.status[pmpc_pkg::ST_LEFT];
  assign res_o.btn_right  = pkt_i.status[pmpc_pkg::ST_RIGHT];
  assign res_o.btn_middle = pkt_i.status[pmpc_pkg::ST_MIDDLE];
  assign res_o.ovf_x      = pkt_i.status[pmpc_pkg::ST_X_OVF];
  assign res_o.ovf_y      = pkt_i.status[pmpc_pkg::ST_Y_OVF];

endmodule

@@ hdl/ps2_mouse_packet_cursor.sv @@
// top level of the ps2 mouse three-byte packet decoder with clamped cursor
// the third byte of a packet is taken into the packet register, its word then into the output register
// throughput: one byte per cycle, set by the packet register and the output register
// backpressure on the output stalls input only when both registers hold a word
// reset: byte phase and cursor go to zero, screen size to 1024 by 768, no word pending
module ps2_mouse_packet_cursor #(
  parameter int COORD_BITS = pmpc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  logic [pmpc_pkg::SIZE_W-1:0]       cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_byte
  input  logic [pmpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cursor_x, cursor_y, delta_x, delta_y, btn_left, btn_right,
  // btn_middle, ovf_x, ovf_y, zero pad
  output logic [pmpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  logic [pmpc_pkg::SIZE_W-1:0] width_q, height_q;
  logic                        in_acc;
  logic                        frame_done;
  pmpc_pkg::pkt_t              frame_pkt;
  logic                        pkt_valid_q;
  pmpc_pkg::pkt_t              pkt_q;
  logic                        adv;
  pmpc_pkg::res_t              res;
  logic                        out_valid_q;
  pmpc_pkg::res_t              out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pmpc_pkg::WIDTH_RESET;
      height_q <= pmpc_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pmpc_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        pmpc_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  assign adv           = pkt_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pkt_valid_q || !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  pmpc_framer u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_acc),
    .byte_i (s_axis_tdata[pmpc_pkg::BYTE_W-1:0]),
    .done_o (frame_done),
    .pkt_o  (frame_pkt)
  );

  // packet register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      pkt_valid_q <= frame_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      pkt_q <= frame_pkt;
    end
  end

  pmpc_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .pkt_i    (pkt_q),
    .width_i  (width_q),
    .height_i (height_q),
    .res_o    (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{pmpc_pkg::OUT_PAD_W{1'b0}}, out_q};

endmodule

@@ hdl/pmpc_checker.sv @@
// port-level checker for the ps2 mouse packet cursor, bound to the top level
`include "ps2_mouse_packet_cursor_macros.svh"

module pmpc_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [pmpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // a stalled word holds
  `PMPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

  // input stalls only behind a stalled output word
  `PMPC_ASSERT_NOW(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

  // a clamped cursor never reaches the all-ones column or row
  `PMPC_ASSERT_NOW(a_x_range, m_axis_tvalid, m_axis_tdata[11:0] != 12'hFFF, "cursor x out of range")
  `PMPC_ASSERT_NOW(a_y_range, m_axis_tvalid, m_axis_tdata[23:12] != 12'hFFF, "cursor y out of range")

endmodule

bind ps2_mouse_packet_cursor pmpc_checker u_pmpc_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench for the ps2 mouse packet cursor: directed packets and random byte streams against a cursor predictor
module testbench;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int SETTLE_CYCLES   = 4;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic                             cfg_addr_i    = pmpc_pkg::REG_SCREEN_WIDTH;
  logic [pmpc_pkg::SIZE_W-1:0]      cfg_data_i    = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // data_byte
  logic [pmpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // cursor_x, cursor_y, delta_x, delta_y, btn_left, btn_right,
  // btn_middle, ovf_x, ovf_y, zero pad
  logic [pmpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  logic [pmpc_pkg::BYTE_W-1:0] mouse_bytes[$];
  pmpc_pkg::res_t              cursor_words[$];

  logic [1:0]                    pkt_phase  = pmpc_pkg::PH_STATUS;
  logic [pmpc_pkg::BYTE_W-1:0]   pkt_status = '0;
  logic [pmpc_pkg::BYTE_W-1:0]   pkt_x      = '0;
  logic [pmpc_pkg::CURSOR_W-1:0] cur_x      = '0;
  logic [pmpc_pkg::CURSOR_W-1:0] cur_y      = '0;
  logic [pmpc_pkg::SIZE_W-1:0]   scr_w      = pmpc_pkg::WIDTH_RESET;
  logic [pmpc_pkg::SIZE_W-1:0]   scr_h      = pmpc_pkg::HEIGHT_RESET;

  int errors       = 0;
  int idle_pct     = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  ps2_mouse_packet_cursor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [pmpc_pkg::CURSOR_W-1:0] clamp_axis(int v,
                                                              logic [pmpc_pkg::SIZE_W-1:0] size);
    int top;
    top = (size == '0) ? 0 : int'(size) - 1;
    if (v <= 0) return '0;
    if (v > top) return pmpc_pkg::CURSOR_W'(top);
    return pmpc_pkg::CURSOR_W'(v);
  endfunction

  function automatic void take_byte(logic [pmpc_pkg::BYTE_W-1:0] b);
    int             dx;
    int             dy;
    pmpc_pkg::res_t w;
    if (pkt_phase == pmpc_pkg::PH_X) begin
      pkt_x     = b;
      pkt_phase = pmpc_pkg::PH_Y;
    end else if (pkt_phase != pmpc_pkg::PH_Y) begin
      pkt_status = b;
      pkt_phase  = pmpc_pkg::PH_X;
    end else begin
      dx = int'(pkt_x) - (pkt_status[pmpc_pkg::ST_X_SIGN] ? 256 : 0);
      dy = int'(b) - (pkt_status[pmpc_pkg::ST_Y_SIGN] ? 256 : 0);
      cur_x = clamp_axis(int'(cur_x) + dx, scr_w);
      cur_y = clamp_axis(int'(cur_y) - dy, scr_h);
      pkt_phase = pmpc_pkg::PH_STATUS;
      w.cursor_x   = cur_x;
      w.cursor_y   = cur_y;
      w.delta_x    = dx[pmpc_pkg::DELTA_W-1:0];
      w.delta_y    = dy[pmpc_pkg::DELTA_W-1:0];
      w.btn_left   = pkt_status[pmpc_pkg::ST_LEFT];
      w.btn_right  = pkt_status[pmpc_pkg::ST_RIGHT];
      w.btn_middle = pkt_status[pmpc_pkg::ST_MIDDLE];
      w.ovf_x      = pkt_status[pmpc_pkg::ST_X_OVF];
      w.ovf_y      = pkt_status[pmpc_pkg::ST_Y_OVF];
      cursor_words.push_back(w);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic logic [pmpc_pkg::BYTE_W-1:0] motion_byte();
    case ($urandom_range(0, 3))
      0:       return pmpc_pkg::BYTE_W'($urandom_range(0, 7));
      1:       return pmpc_pkg::BYTE_W'($urandom_range(248, 255));
      default: return pmpc_pkg::BYTE_W'($urandom);
    endcase
  endfunction

  function automatic void add_packet(logic [pmpc_pkg::BYTE_W-1:0] st,
                                     logic [pmpc_pkg::BYTE_W-1:0] xb,
                                     logic [pmpc_pkg::BYTE_W-1:0] yb);
    mouse_bytes.push_back(st);
    mouse_bytes.push_back(xb);
    mouse_bytes.push_back(yb);
  endfunction

  // mostly well-formed packets, now and then a stray byte that shifts the framing
  function automatic void add_random(int n);
    logic [pmpc_pkg::BYTE_W-1:0] st;
    logic [pmpc_pkg::BYTE_W-1:0] xb;
    logic [pmpc_pkg::BYTE_W-1:0] yb;
    int                          cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 19) == 0) begin
        mouse_bytes.push_back(pmpc_pkg::BYTE_W'($urandom));
        cnt += 1;
      end else begin
        st = pmpc_pkg::BYTE_W'($urandom);
        xb = motion_byte();
        yb = motion_byte();
        if ($urandom_range(0, 7) != 0) st[3] = 1'b1;
        if ($urandom_range(0, 3) != 0) st[pmpc_pkg::ST_X_SIGN] = xb[7];
        if ($urandom_range(0, 3) != 0) st[pmpc_pkg::ST_Y_SIGN] = yb[7];
        add_packet(st, xb, yb);
        cnt += 3;
      end
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (mouse_bytes.size() != 0 || s_axis_tvalid || cursor_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [pmpc_pkg::SIZE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pmpc_pkg::REG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
  endtask

  task automatic run_phase(logic [pmpc_pkg::SIZE_W-1:0] w, logic [pmpc_pkg::SIZE_W-1:0] h,
                           int pct, int n);
    write_reg(pmpc_pkg::REG_SCREEN_WIDTH, w);
    write_reg(pmpc_pkg::REG_SCREEN_HEIGHT, h);
    idle_pct = pct;
    add_random(n / 2);
    wait_drained();
    add_random(n - n / 2);
    wait_drained();
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (mouse_bytes.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 6);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= mouse_bytes.pop_front();
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pmpc_pkg::res_t got;
    pmpc_pkg::res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = pmpc_pkg::res_t'(m_axis_tdata[$bits(pmpc_pkg::res_t)-1:0]);
        if (cursor_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, got %h", $time, m_axis_tdata);
        end else begin
          want = cursor_words.pop_front();
          check_field("cursor_x", want.cursor_x, got.cursor_x);
          check_field("cursor_y", want.cursor_y, got.cursor_y);
          check_field("delta_x", int'(want.delta_x), int'(got.delta_x));
          check_field("delta_y", int'(want.delta_y), int'(got.delta_y));
          check_field("btn_left", want.btn_left, got.btn_left);
          check_field("btn_right", want.btn_right, got.btn_right);
          check_field("btn_middle", want.btn_middle, got.btn_middle);
          check_field("ovf_x", want.ovf_x, got.ovf_x);
          check_field("ovf_y", want.ovf_y, got.ovf_y);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed packets at the reset screen size
    add_packet(8'h08, 8'h00, 8'h00);
    add_packet(8'hFF, 8'hFF, 8'hFF);
    add_packet(8'h0F, 8'hFF, 8'h00);
    add_packet(8'h38, 8'h00, 8'h00);
    add_packet(8'hC8, 8'h7F, 8'h80);
    add_packet(8'h28, 8'h00, 8'h00);
    add_packet(8'h20, 8'h00, 8'h00);
    add_packet(8'h00, 8'hFF, 8'h01);
    wait_drained();

    run_phase(12'd4095, 12'd4095, 30, 190);
    run_phase(12'd1, 12'd1, 10, 190);
    run_phase(12'd0, 12'd0, 50, 150);
    run_phase(12'd0, 12'd4095, 20, 150);
    run_phase(12'd4095, 12'd1, 30, 150);
    run_phase(12'd640, 12'd480, 60, 190);
    repeat (2) begin
      run_phase(pmpc_pkg::SIZE_W'($urandom_range(1, 4095)),
                pmpc_pkg::SIZE_W'($urandom_range(1, 4095)), 20, 150);
    end
    run_phase(pmpc_pkg::WIDTH_RESET, pmpc_pkg::HEIGHT_RESET, 0, 200);

    if (errors == 0 && cursor_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
